[hw/rtl/floppy_block_to_sector_sequencer_defines.svh]
// Assertion macros shared by the floppy sequencer RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef FLOPPY_BLOCK_TO_SECTOR_SEQUENCER_DEFINES_SVH
`define FLOPPY_BLOCK_TO_SECTOR_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every edge out of reset.
`define FBSS_ASSERT(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("fbss check failed");

// Same-cycle implication.
`define FBSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fbss check failed");

// Next-cycle implication.
`define FBSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fbss check failed");

`else

`define FBSS_ASSERT(label, clk, rstn, expr)
`define FBSS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FBSS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/fbss_pkg.sv]
// Types, constants and codes for the floppy block-to-sector sequencer.
// No dependencies; used by every RTL module of the block.
package fbss_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int MAX_SECTORS  = 31;

    localparam int CMD_W        = 2;
    localparam int BLOCK_W      = 16;
    localparam int BYTE_COUNT_W = 14;
    localparam int ADDR_W       = 24;
    localparam int KIND_W       = 2;
    localparam int OPCODE_W     = 8;
    localparam int CYL_W        = 7;
    localparam int HEAD_W       = 7;
    localparam int SEC_W        = 6;
    localparam int DMA_ADDR_W   = 23;
    localparam int DMA_CNT_W    = 16;
    localparam int SPT_W        = 6;
    localparam int SPC_W        = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;

    // Whole sectors in the largest byte count
    localparam int SECT_CNT_W   = $clog2((2 ** BYTE_COUNT_W) / SECTOR_BYTES);

    // Serial divider: block number over sectors per cylinder
    localparam int DIV_W        = BLOCK_W;
    localparam int DIVISOR_W    = SPC_W;
    localparam int DIV_CNT_W    = $clog2(DIV_W);

    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SEEK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_XFER    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    localparam logic [OPCODE_W-1:0] OP_READ    = 8'h88;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 8'ha8;
    localparam logic [OPCODE_W-1:0] OP_SIDE    = 8'h02;
    localparam logic [OPCODE_W-1:0] OP_SEEK    = 8'h14;
    localparam logic [OPCODE_W-1:0] OP_RESTORE = 8'h04;

    localparam logic [DMA_CNT_W-1:0] DMA_COUNT = DMA_CNT_W'(-(SECTOR_BYTES / 2));

    localparam logic [CFG_INDEX_W-1:0] REG_SPT       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPC       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CYL_COUNT = 2'd2;

    localparam logic [SPT_W-1:0] SPT_RESET       = 6'd9;
    localparam logic [SPC_W-1:0] SPC_RESET       = 7'd18;
    localparam logic [CYL_W-1:0] CYL_COUNT_RESET = 7'd40;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [BLOCK_W-1:0]      start_block;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic [ADDR_W-1:0]       buffer_address;
    } fbss_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]       item_kind;
        logic [OPCODE_W-1:0]     command_byte;
        logic [CYL_W-1:0]        cylinder;
        logic [HEAD_W-1:0]       head;
        logic [SEC_W-1:0]        sector;
        logic [DMA_ADDR_W-1:0]   dma_word_address;
        logic [DMA_CNT_W-1:0]    dma_count;
        logic [BYTE_COUNT_W-1:0] bytes_done;
        logic                    last;
    } fbss_out_t;

    typedef struct packed {
        logic [SPT_W-1:0] sectors_per_track;
        logic [SPC_W-1:0] sectors_per_cylinder;
        logic [CYL_W-1:0] cylinder_count;
    } fbss_cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } fbss_div_ctrl_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_W-1:0]     quotient;
        logic [DIVISOR_W-1:0] remainder;
    } fbss_div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_CYL,
        ST_DIV_HEAD,
        ST_CHECK,
        ST_SEEK,
        ST_XFER,
        ST_RESTORE,
        ST_DONE
    } fbss_state_t;

endpackage

[hw/rtl/fbss_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on fbss_pkg and the assertion macro header.
`include "floppy_block_to_sector_sequencer_defines.svh"

module fbss_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fbss_pkg::fbss_div_ctrl_t ctrl,
    output fbss_pkg::fbss_div_stat_t stat
);
    import fbss_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvsr_reg, dvsr_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // Shift the next dividend bit into the partial remainder and try to subtract
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            quo_next  = ctrl.dividend;
            rem_next  = '0;
            dvsr_next = ctrl.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

    `FBSS_ASSERT_IMP(a_div_no_restart, aclk, aresetn, ctrl.start, !busy_reg)
    `FBSS_ASSERT_IMP(a_div_done_idle, aclk, aresetn, done_reg, !busy_reg)

endmodule

[hw/rtl/fbss_seq.sv]
// Request sequencer: a restore item, or geometry split via the serial divider,
// then a transfer item per sector (a seek item where needed) and a closing
// item. Depends on fbss_pkg, fbss_div status and the assertion macro header.
`include "floppy_block_to_sector_sequencer_defines.svh"

module fbss_seq (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  fbss_pkg::fbss_in_t       s_payload,
    input  fbss_pkg::fbss_cfg_t      cfg,
    output logic                     item_valid,
    input  logic                     item_ready,
    output fbss_pkg::fbss_out_t      item,
    output fbss_pkg::fbss_div_ctrl_t div_ctrl,
    input  fbss_pkg::fbss_div_stat_t div_stat
);
    import fbss_pkg::*;

    fbss_state_t             state_reg, state_next;
    logic                    write_reg, write_next;
    logic [BYTE_COUNT_W-1:0] count_reg, count_next;
    logic [SECT_CNT_W-1:0]   total_reg, total_next;
    logic [SECT_CNT_W-1:0]   todo_reg, todo_next;
    logic [SECT_CNT_W-1:0]   moved_reg, moved_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [BLOCK_W-1:0]      cyl_reg, cyl_next;
    logic [SPC_W-1:0]        within_reg, within_next;
    logic [HEAD_W-1:0]       hd_reg, hd_next;
    logic [SEC_W-1:0]        sec_reg, sec_next;
    logic [CYL_W-1:0]        head_cyl_reg, head_cyl_next;
    logic                    known_reg, known_next;

    logic                    accept;
    logic                    is_xfer_cmd;
    logic                    geom_ok;
    logic                    past_end;
    logic                    need_seek;
    logic [SECT_CNT_W-1:0]   in_total;
    logic [SPC_W-1:0]        within_inc;
    logic [SEC_W-1:0]        sec_inc;

    assign accept      = s_valid && s_ready;
    assign is_xfer_cmd = (s_payload.command == CMD_READ) || (s_payload.command == CMD_WRITE);
    assign geom_ok     = (cfg.sectors_per_track != '0) && (cfg.sectors_per_cylinder != '0);
    assign past_end    = cyl_reg >= BLOCK_W'(cfg.cylinder_count);
    assign need_seek   = !known_reg || (cyl_reg != BLOCK_W'(head_cyl_reg));
    assign in_total    = SECT_CNT_W'(s_payload.byte_count / SECTOR_BYTES);
    assign within_inc  = within_reg + SPC_W'(1);
    assign sec_inc     = sec_reg + SEC_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (is_xfer_cmd) begin
                        state_next = geom_ok ? ST_DIV_CYL : ST_DONE;
                    end else if (s_payload.command == CMD_RESTORE) begin
                        state_next = ST_RESTORE;
                    end
                end
            end
            ST_DIV_CYL: begin
                if (div_stat.done) begin
                    state_next = ST_DIV_HEAD;
                end
            end
            ST_DIV_HEAD: begin
                if (div_stat.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (moved_reg == todo_reg || past_end) begin
                    state_next = ST_DONE;
                end else if (need_seek) begin
                    state_next = ST_SEEK;
                end else begin
                    state_next = ST_XFER;
                end
            end
            ST_SEEK: begin
                if (item_ready) begin
                    state_next = ST_XFER;
                end
            end
            ST_XFER: begin
                if (item_ready) begin
                    state_next = ST_CHECK;
                end
            end
            ST_RESTORE, ST_DONE: begin
                if (item_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, divider control and the result item
    always_comb begin
        s_ready           = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = s_payload.start_block;
        div_ctrl.divisor  = cfg.sectors_per_cylinder;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                div_ctrl.start = s_valid && is_xfer_cmd && geom_ok;
            end
            ST_DIV_CYL: begin
                // Remainder of the cylinder split feeds the head/sector split
                div_ctrl.start    = div_stat.done;
                div_ctrl.dividend = DIV_W'(div_stat.remainder);
                div_ctrl.divisor  = DIVISOR_W'(cfg.sectors_per_track);
            end
            ST_SEEK: begin
                item_valid        = 1'b1;
                item.item_kind    = KIND_SEEK;
                item.command_byte = OP_SEEK;
                item.cylinder     = cyl_reg[CYL_W-1:0];
            end
            ST_XFER: begin
                item_valid        = 1'b1;
                item.item_kind    = KIND_XFER;
                item.command_byte = (write_reg ? OP_WRITE : OP_READ)
                                  | ((hd_reg != '0) ? OP_SIDE : '0);
                item.cylinder     = cyl_reg[CYL_W-1:0];
                item.head         = hd_reg;
                item.sector       = sec_inc;
                item.dma_word_address = addr_reg[ADDR_W-1:1];
                item.dma_count    = DMA_COUNT;
            end
            ST_RESTORE: begin
                item_valid        = 1'b1;
                item.item_kind    = KIND_RESTORE;
                item.command_byte = OP_RESTORE;
                item.last         = 1'b1;
            end
            ST_DONE: begin
                item_valid        = 1'b1;
                item.item_kind    = KIND_DONE;
                item.bytes_done   = count_reg - BYTE_COUNT_W'(
                                    int'(total_reg - moved_reg) * SECTOR_BYTES);
                item.last         = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        write_next    = write_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        todo_next     = todo_reg;
        moved_next    = moved_reg;
        addr_next     = addr_reg;
        cyl_next      = cyl_reg;
        within_next   = within_reg;
        hd_next       = hd_reg;
        sec_next      = sec_reg;
        head_cyl_next = head_cyl_reg;
        known_next    = known_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    write_next = s_payload.command == CMD_WRITE;
                    count_next = s_payload.byte_count;
                    total_next = in_total;
                    todo_next  = (int'(in_total) > MAX_SECTORS) ?
                                 SECT_CNT_W'(MAX_SECTORS) : in_total;
                    moved_next = '0;
                    addr_next  = s_payload.buffer_address;
                end
            end
            ST_DIV_CYL: begin
                if (div_stat.done) begin
                    cyl_next    = div_stat.quotient;
                    within_next = div_stat.remainder;
                end
            end
            ST_DIV_HEAD: begin
                if (div_stat.done) begin
                    hd_next  = HEAD_W'(div_stat.quotient);
                    sec_next = SEC_W'(div_stat.remainder);
                end
            end
            ST_SEEK: begin
                if (item_ready) begin
                    head_cyl_next = cyl_reg[CYL_W-1:0];
                    known_next    = 1'b1;
                end
            end
            ST_XFER: begin
                if (item_ready) begin
                    moved_next = moved_reg + SECT_CNT_W'(1);
                    addr_next  = addr_reg + ADDR_W'(SECTOR_BYTES);
                    // Advance to the next block: sector, then head, then cylinder
                    if (within_inc == cfg.sectors_per_cylinder) begin
                        within_next = '0;
                        hd_next     = '0;
                        sec_next    = '0;
                        cyl_next    = cyl_reg + BLOCK_W'(1);
                    end else begin
                        within_next = within_inc;
                        if (sec_inc == cfg.sectors_per_track) begin
                            sec_next = '0;
                            hd_next  = hd_reg + HEAD_W'(1);
                        end else begin
                            sec_next = sec_inc;
                        end
                    end
                end
            end
            ST_RESTORE: begin
                if (item_ready) begin
                    head_cyl_next = '0;
                    known_next    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_cyl_reg <= '0;
            known_reg    <= 1'b0;
            total_reg    <= '0;
            todo_reg     <= '0;
            moved_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            head_cyl_reg <= head_cyl_next;
            known_reg    <= known_next;
            total_reg    <= total_next;
            todo_reg     <= todo_next;
            moved_reg    <= moved_next;
        end
        write_reg  <= write_next;
        count_reg  <= count_next;
        addr_reg   <= addr_next;
        cyl_reg    <= cyl_next;
        within_reg <= within_next;
        hd_reg     <= hd_next;
        sec_reg    <= sec_next;
    end

    `FBSS_ASSERT(a_moved_in_range, aclk, aresetn, moved_reg <= todo_reg && todo_reg <= total_reg)
    `FBSS_ASSERT_IMP(a_xfer_on_track, aclk, aresetn,
        item_valid && item.item_kind == KIND_XFER,
        known_reg && cyl_reg == BLOCK_W'(head_cyl_reg) && !past_end)
    `FBSS_ASSERT_NEXT(a_position_kept, aclk, aresetn, known_reg, known_reg)
    `FBSS_ASSERT_IMP(a_div_only_when_splitting, aclk, aresetn, div_stat.done,
        state_reg == ST_DIV_CYL || state_reg == ST_DIV_HEAD)

endmodule

[hw/rtl/floppy_block_to_sector_sequencer.sv]
// A restore item, or the done item of a read or write under zero geometry, reaches m_valid
// through the state register, then the output register. Otherwise two 16-step bit-serial
// divisions (cylinder, then head/sector) run first, then a seek item if the head position is
// unknown or differs, one transfer item per sector and the done item. One request at a time:
// the next is accepted in the cycle after the closing item is taken into the output register.
// Reset (aresetn low, synchronous): geometry 9/18/40, head position unknown, queue empty.
module floppy_block_to_sector_sequencer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  fbss_pkg::fbss_in_t                    s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output fbss_pkg::fbss_out_t                   m_payload,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fbss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fbss_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fbss_pkg::*;

    logic [SPT_W-1:0] spt_reg, spt_next;
    logic [SPC_W-1:0] spc_reg, spc_next;
    logic [CYL_W-1:0] cyl_count_reg, cyl_count_next;

    logic             out_valid_reg, out_valid_next;
    fbss_out_t        out_item_reg, out_item_next;

    fbss_cfg_t        cfg;
    logic             item_valid;
    logic             item_ready;
    fbss_out_t        item;
    fbss_div_ctrl_t   div_ctrl;
    fbss_div_stat_t   div_stat;

    assign cfg_ready = 1'b1;

    always_comb begin
        spt_next       = spt_reg;
        spc_next       = spc_reg;
        cyl_count_next = cyl_count_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SPT:       spt_next       = cfg_data[SPT_W-1:0];
                REG_SPC:       spc_next       = cfg_data[SPC_W-1:0];
                REG_CYL_COUNT: cyl_count_next = cfg_data[CYL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.sectors_per_track    = spt_reg;
    assign cfg.sectors_per_cylinder = spc_reg;
    assign cfg.cylinder_count       = cyl_count_reg;

    // Output register: load a new item whenever the slot is empty or draining
    assign item_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (item_valid && item_ready) begin
            out_valid_next = 1'b1;
            out_item_next  = item;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg       <= SPT_RESET;
            spc_reg       <= SPC_RESET;
            cyl_count_reg <= CYL_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            spt_reg       <= spt_next;
            spc_reg       <= spc_next;
            cyl_count_reg <= cyl_count_next;
            out_valid_reg <= out_valid_next;
        end
        out_item_reg <= out_item_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    fbss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    fbss_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .div_ctrl   (div_ctrl),
        .div_stat   (div_stat)
    );

endmodule
